[rtl/i2c_master_byte_engine_assert.svh]
// Assertion macros used by the I2C master byte engine core.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define I2C_MBE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("i2c engine check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define I2C_MBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("i2c engine check failed");

`endif

[rtl/i2c_mbe_pkg.sv]
// Package with the shared types and constants of the I2C master byte engine.
package i2c_mbe_pkg;

    // Command codes carried by each tick.
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_START_HOLD  = 2'd0,
        CFG_STOP_SETUP  = 2'd1,
        CFG_BUS_FREE    = 2'd2,
        CFG_ACK_TIMEOUT = 2'd3
    } t_cfg_index;

    // Reset values of the configuration registers.
    localparam logic [7:0] START_HOLD_RESET  = 8'd4;
    localparam logic [7:0] STOP_SETUP_RESET = 8'd4;
    localparam logic [7:0] BUS_FREE_RESET   = 8'd5;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    // Number of bits in one byte transfer.
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Bus sequencer phases.
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_REL, PH_ST_SCLH, PH_ST_HOLD, PH_ST_SDAL, PH_ST_SCLL,
        PH_SP_SCLL, PH_SP_SDAL, PH_SP_HOLD, PH_SP_SCLH, PH_SP_SDAH, PH_SP_FREE,
        PH_WR_DATA, PH_WR_SCLH, PH_WR_SCLL, PH_WA_REL, PH_WA_SCLH, PH_WA_POLL,
        PH_RD_REL, PH_RD_SCLH, PH_RD_SAMP, PH_AK_SDA, PH_AK_SCLH, PH_AK_SCLL
    } t_phase;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] start_hold;
        logic [7:0] stop_setup;
        logic [7:0] bus_free;
        logic [7:0] ack_timeout;
    } t_cfg;

    // One result word.
    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_result;

endpackage

[rtl/i2c_mbe_cfg.sv]
// Configuration register file of the I2C master byte engine.
module i2c_mbe_cfg
    import i2c_mbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  logic [1:0] i_index,
    input  logic [7:0] i_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    // Registers take a write by index; there is no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_hold  <= START_HOLD_RESET;
            r_cfg.stop_setup  <= STOP_SETUP_RESET;
            r_cfg.bus_free    <= BUS_FREE_RESET;
            r_cfg.ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_wr) begin
            case (i_index)
                CFG_START_HOLD:  r_cfg.start_hold  <= i_data;
                CFG_STOP_SETUP:  r_cfg.stop_setup  <= i_data;
                CFG_BUS_FREE:    r_cfg.bus_free    <= i_data;
                CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/i2c_mbe_core.sv]
// Bus sequencer of the I2C master byte engine: one step per accepted tick.
module i2c_mbe_core
    import i2c_mbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_sda_in,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

`include "i2c_master_byte_engine_assert.svh"

    t_phase     r_phase, n_phase;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_shift, n_shift;
    logic [8:0] r_timer, n_timer;
    logic       r_ack_choice, n_ack_choice;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_rx, n_rx;
    logic       r_err, n_err;
    logic       n_done;

    logic [3:0] bit_inc;
    logic [8:0] timer_inc;
    logic       timer_last;
    logic       ack_expired;

    // Shared counter arithmetic.
    assign bit_inc     = r_bit_count + 4'd1;
    assign timer_inc   = r_timer + 9'd1;
    assign timer_last  = (r_timer == 9'd1);
    assign ack_expired = (timer_inc > {1'b0, i_cfg.ack_timeout});

    // Next phase. Start and stop perform their first step on the accepting tick.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                case (i_cmd)
                    CMD_START: n_phase = PH_ST_SCLH;
                    CMD_STOP:  n_phase = PH_SP_SDAL;
                    CMD_WRITE: n_phase = PH_WR_DATA;
                    CMD_READ:  n_phase = PH_RD_REL;
                    default:   n_phase = PH_IDLE;
                endcase
            end
            PH_ST_REL:  n_phase = PH_ST_SCLH;
            PH_ST_SCLH: n_phase = (i_cfg.start_hold == 8'd0) ? PH_ST_SDAL : PH_ST_HOLD;
            PH_ST_HOLD: n_phase = timer_last ? PH_ST_SDAL : PH_ST_HOLD;
            PH_ST_SDAL: n_phase = PH_ST_SCLL;
            PH_ST_SCLL: n_phase = PH_IDLE;
            PH_SP_SCLL: n_phase = PH_SP_SDAL;
            PH_SP_SDAL: n_phase = (i_cfg.stop_setup == 8'd0) ? PH_SP_SCLH : PH_SP_HOLD;
            PH_SP_HOLD: n_phase = timer_last ? PH_SP_SCLH : PH_SP_HOLD;
            PH_SP_SCLH: n_phase = PH_SP_SDAH;
            PH_SP_SDAH: n_phase = (i_cfg.bus_free == 8'd0) ? PH_IDLE : PH_SP_FREE;
            PH_SP_FREE: n_phase = timer_last ? PH_IDLE : PH_SP_FREE;
            PH_WR_DATA: n_phase = PH_WR_SCLH;
            PH_WR_SCLH: n_phase = PH_WR_SCLL;
            PH_WR_SCLL: n_phase = (bit_inc >= BITS_PER_BYTE) ? PH_WA_REL : PH_WR_DATA;
            PH_WA_REL:  n_phase = PH_WA_SCLH;
            PH_WA_SCLH: n_phase = PH_WA_POLL;
            PH_WA_POLL: begin
                if (!i_sda_in) begin
                    n_phase = PH_IDLE;
                end else if (ack_expired) begin
                    n_phase = PH_SP_SDAL;
                end
            end
            PH_RD_REL:  n_phase = PH_RD_SCLH;
            PH_RD_SCLH: n_phase = PH_RD_SAMP;
            PH_RD_SAMP: n_phase = (bit_inc >= BITS_PER_BYTE) ? PH_AK_SDA : PH_RD_SCLH;
            PH_AK_SDA:  n_phase = PH_AK_SCLH;
            PH_AK_SCLH: n_phase = PH_AK_SCLL;
            PH_AK_SCLL: n_phase = PH_IDLE;
            default:    n_phase = PH_IDLE;
        endcase
    end

    // Line levels, counters, shifter and status for this tick.
    always_comb begin
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_timer      = r_timer;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_rx         = r_rx;
        n_err        = r_err;
        n_done       = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                case (i_cmd)
                    CMD_START: n_sda = 1'b1;
                    CMD_STOP:  n_scl = 1'b0;
                    CMD_WRITE: begin
                        n_shift     = i_tx_byte;
                        n_bit_count = 4'd0;
                        n_err       = 1'b0;
                        n_scl       = 1'b0;
                    end
                    CMD_READ: begin
                        n_ack_choice = i_send_ack;
                        n_shift      = 8'd0;
                        n_bit_count  = 4'd0;
                        n_scl        = 1'b0;
                    end
                    default: ;
                endcase
            end
            PH_ST_REL: n_sda = 1'b1;
            PH_ST_SCLH: begin
                n_scl = 1'b1;
                if (i_cfg.start_hold != 8'd0) begin
                    n_timer = {1'b0, i_cfg.start_hold};
                end
            end
            PH_ST_HOLD: n_timer = r_timer - 9'd1;
            PH_ST_SDAL: n_sda = 1'b0;
            PH_ST_SCLL: begin
                n_scl  = 1'b0;
                n_done = 1'b1;
            end
            PH_SP_SCLL: n_scl = 1'b0;
            PH_SP_SDAL: begin
                n_sda = 1'b0;
                if (i_cfg.stop_setup != 8'd0) begin
                    n_timer = {1'b0, i_cfg.stop_setup};
                end
            end
            PH_SP_HOLD: n_timer = r_timer - 9'd1;
            PH_SP_SCLH: n_scl = 1'b1;
            PH_SP_SDAH: begin
                n_sda = 1'b1;
                if (i_cfg.bus_free == 8'd0) begin
                    n_done = 1'b1;
                end else begin
                    n_timer = {1'b0, i_cfg.bus_free};
                end
            end
            PH_SP_FREE: begin
                n_timer = r_timer - 9'd1;
                n_done  = timer_last;
            end
            PH_WR_DATA: begin
                n_sda   = r_shift[7];
                n_shift = {r_shift[6:0], 1'b0};
            end
            PH_WR_SCLH: n_scl = 1'b1;
            PH_WR_SCLL: begin
                n_scl       = 1'b0;
                n_bit_count = bit_inc;
            end
            PH_WA_REL: n_sda = 1'b1;
            PH_WA_SCLH: begin
                n_scl   = 1'b1;
                n_timer = 9'd0;
            end
            PH_WA_POLL: begin
                if (!i_sda_in) begin
                    n_scl  = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_timer = timer_inc;
                    if (ack_expired) begin
                        n_scl = 1'b0;
                        n_err = 1'b1;
                    end
                end
            end
            PH_RD_REL:  n_sda = 1'b1;
            PH_RD_SCLH: n_scl = 1'b1;
            PH_RD_SAMP: begin
                n_shift     = {r_shift[6:0], i_sda_in};
                n_bit_count = bit_inc;
                n_scl       = 1'b0;
            end
            PH_AK_SDA:  n_sda = ~r_ack_choice;
            PH_AK_SCLH: n_scl = 1'b1;
            PH_AK_SCLL: begin
                n_scl  = 1'b0;
                n_rx   = r_shift;
                n_done = 1'b1;
            end
            default: ;
        endcase
    end

    // Sequencer state advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= 4'd0;
            r_shift      <= 8'd0;
            r_timer      <= 9'd0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_rx         <= 8'd0;
            r_err        <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_timer      <= n_timer;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_rx         <= n_rx;
            r_err        <= n_err;
        end
    end

    // Result of this tick, taken from the next-state values.
    always_comb begin
        o_res.scl_level   = n_scl;
        o_res.sda_release = n_sda;
        o_res.busy        = (n_phase != PH_IDLE);
        o_res.done        = n_done;
        o_res.rx_byte     = n_rx;
        o_res.ack_error   = n_err;
    end

    // A finishing tick always leaves the sequencer idle with SCL low or released.
    `I2C_MBE_ASSERT_NOW(a_done_idle, n_done, n_phase == PH_IDLE)
    // The ack error can only be raised by a poll tick.
    `I2C_MBE_ASSERT_NOW(a_err_from_poll, $rose(r_err), $past(r_phase) == PH_WA_POLL)
    // An accepted write in idle clears the error and starts the first data bit.
    `I2C_MBE_ASSERT_NEXT(a_write_start,
        i_step && (r_phase == PH_IDLE) && (i_cmd == CMD_WRITE),
        (r_phase == PH_WR_DATA) && !r_err && !r_scl)
    // The bit counter never runs past one byte.
    `I2C_MBE_ASSERT_NOW(a_bit_range, r_phase != PH_IDLE, r_bit_count <= BITS_PER_BYTE)

endmodule

[rtl/i2c_master_byte_engine.sv]
// Output: the result word of an accepted tick is registered in the output register.
// Throughput: one tick per cycle; a result waiting under stall holds the next tick back.
// Each bus line change takes one tick; holds last as many ticks as set; the ACK poll ends on ACK or timeout.
// Reset: synchronous, active low; idle phase, both lines released, state and configuration registers to defaults.
// The configuration port is always ready.
module i2c_master_byte_engine
    import i2c_mbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_level,
    output logic       o_sda_release,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_error,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg    cfg;
    t_result step_res;
    logic    step;
    logic    r_out_valid;
    t_result r_res;

    // Configuration writes are taken in every cycle.
    assign o_cfg_ready = 1'b1;

    i2c_mbe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // A tick is taken whenever the output register is free or being emptied.
    assign o_stall = r_out_valid && i_stall;
    assign step    = i_valid && !o_stall;

    i2c_mbe_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_cmd      (i_cmd),
        .i_tx_byte  (i_tx_byte),
        .i_send_ack (i_send_ack),
        .i_sda_in   (i_sda_in),
        .i_cfg      (cfg),
        .o_res      (step_res)
    );

    // Output register for the result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= step_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_scl_level   = r_res.scl_level;
    assign o_sda_release = r_res.sda_release;
    assign o_busy_res    = r_res.busy;
    assign o_done_res    = r_res.done;
    assign o_rx_byte     = r_res.rx_byte;
    assign o_ack_error   = r_res.ack_error;

endmodule

[tb/sv/tb_i2c_master_byte_engine.sv]
// Self-checking testbench for the I2C master byte engine, with a tick-by-tick bus predictor.
module tb_i2c_master_byte_engine;
    import i2c_mbe_pkg::*;

    localparam int unsigned RUN_LIMIT       = 10_000_000;
    localparam int          OPS_PER_SETTING = 1;
    localparam int          OPS_PER_PHASE   = 3;
    localparam int          HOLD_OFF_CYCLES = 400;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [2:0] i_cmd         = CMD_NONE;
    logic [7:0] i_tx_byte     = 8'd0;
    logic       i_send_ack    = 1'b0;
    logic       i_sda_in      = 1'b1;
    logic       i_stall       = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic [1:0] i_cfg_index   = CFG_START_HOLD;
    logic [7:0] i_cfg_data    = 8'd0;
    logic       o_stall;
    logic       o_valid;
    logic       o_scl_level;
    logic       o_sda_release;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rx_byte;
    logic       o_ack_error;
    logic       o_cfg_ready;

    i2c_master_byte_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_tx_byte     (i_tx_byte),
        .i_send_ack    (i_send_ack),
        .i_sda_in      (i_sda_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_scl_level   (o_scl_level),
        .o_sda_release (o_sda_release),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_rx_byte     (o_rx_byte),
        .o_ack_error   (o_ack_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock with a period of two time units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted engine state and timing registers.
    t_phase     eng_phase;
    logic [3:0] eng_bits;
    logic [7:0] eng_shift;
    logic [8:0] eng_timer;
    logic       eng_ack_sel;
    logic       eng_scl;
    logic       eng_sda;
    logic [7:0] eng_rx;
    logic       eng_err;
    t_cfg       eng_cfg;

    // Predicted line states still waiting for their result word.
    t_result line_state_q[$];

    int   fail_count     = 0;
    int   ops_issued     = 0;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    logic sink_hold      = 1'b0;
    // Chance that the slave leaves SDA high on an ACK poll tick.
    int   ack_high_pct   = 50;
    // Level the slave presents on read ticks: 0 random, 1 all low, 2 all high.
    int   read_level     = 0;

    task automatic reset_engine_model();
        eng_phase   = PH_IDLE;
        eng_bits    = 4'd0;
        eng_shift   = 8'd0;
        eng_timer   = 9'd0;
        eng_ack_sel = 1'b0;
        eng_scl     = 1'b1;
        eng_sda     = 1'b1;
        eng_rx      = 8'd0;
        eng_err     = 1'b0;
        eng_cfg     = '{START_HOLD_RESET, STOP_SETUP_RESET, BUS_FREE_RESET, ACK_TIMEOUT_RESET};
    endtask

    // Advances the predicted engine by one bus tick and returns the line state after it.
    task automatic advance_bus_tick(input logic [2:0] cmd, input logic [7:0] tx,
                                    input logic ack, input logic sda, output t_result res);
        logic run_step;
        logic done;
        done     = 1'b0;
        run_step = 1'b1;
        // An idle engine takes a new command; start and stop do their first step at once.
        if (eng_phase == PH_IDLE) begin
            run_step = 1'b0;
            case (cmd)
                CMD_START: begin
                    eng_phase = PH_ST_REL;
                    run_step  = 1'b1;
                end
                CMD_STOP: begin
                    eng_phase = PH_SP_SCLL;
                    run_step  = 1'b1;
                end
                CMD_WRITE: begin
                    eng_shift = tx;
                    eng_bits  = 4'd0;
                    eng_err   = 1'b0;
                    eng_scl   = 1'b0;
                    eng_phase = PH_WR_DATA;
                end
                CMD_READ: begin
                    eng_ack_sel = ack;
                    eng_shift   = 8'd0;
                    eng_bits    = 4'd0;
                    eng_scl     = 1'b0;
                    eng_phase   = PH_RD_REL;
                end
                default: ;
            endcase
        end
        if (run_step) begin
            case (eng_phase)
                PH_ST_REL: begin
                    eng_sda   = 1'b1;
                    eng_phase = PH_ST_SCLH;
                end
                PH_ST_SCLH: begin
                    eng_scl = 1'b1;
                    if (eng_cfg.start_hold == 8'd0) begin
                        eng_phase = PH_ST_SDAL;
                    end else begin
                        eng_timer = {1'b0, eng_cfg.start_hold};
                        eng_phase = PH_ST_HOLD;
                    end
                end
                PH_ST_HOLD: begin
                    eng_timer = eng_timer - 9'd1;
                    if (eng_timer == 9'd0) eng_phase = PH_ST_SDAL;
                end
                PH_ST_SDAL: begin
                    eng_sda   = 1'b0;
                    eng_phase = PH_ST_SCLL;
                end
                PH_ST_SCLL: begin
                    eng_scl   = 1'b0;
                    done      = 1'b1;
                    eng_phase = PH_IDLE;
                end
                PH_SP_SCLL: begin
                    eng_scl   = 1'b0;
                    eng_phase = PH_SP_SDAL;
                end
                PH_SP_SDAL: begin
                    eng_sda = 1'b0;
                    if (eng_cfg.stop_setup == 8'd0) begin
                        eng_phase = PH_SP_SCLH;
                    end else begin
                        eng_timer = {1'b0, eng_cfg.stop_setup};
                        eng_phase = PH_SP_HOLD;
                    end
                end
                PH_SP_HOLD: begin
                    eng_timer = eng_timer - 9'd1;
                    if (eng_timer == 9'd0) eng_phase = PH_SP_SCLH;
                end
                PH_SP_SCLH: begin
                    eng_scl   = 1'b1;
                    eng_phase = PH_SP_SDAH;
                end
                PH_SP_SDAH: begin
                    eng_sda = 1'b1;
                    if (eng_cfg.bus_free == 8'd0) begin
                        done      = 1'b1;
                        eng_phase = PH_IDLE;
                    end else begin
                        eng_timer = {1'b0, eng_cfg.bus_free};
                        eng_phase = PH_SP_FREE;
                    end
                end
                PH_SP_FREE: begin
                    eng_timer = eng_timer - 9'd1;
                    if (eng_timer == 9'd0) begin
                        done      = 1'b1;
                        eng_phase = PH_IDLE;
                    end
                end
                PH_WR_DATA: begin
                    eng_sda   = eng_shift[7];
                    eng_shift = eng_shift << 1;
                    eng_phase = PH_WR_SCLH;
                end
                PH_WR_SCLH: begin
                    eng_scl   = 1'b1;
                    eng_phase = PH_WR_SCLL;
                end
                PH_WR_SCLL: begin
                    eng_scl   = 1'b0;
                    eng_bits  = eng_bits + 4'd1;
                    eng_phase = (eng_bits >= BITS_PER_BYTE) ? PH_WA_REL : PH_WR_DATA;
                end
                PH_WA_REL: begin
                    eng_sda   = 1'b1;
                    eng_phase = PH_WA_SCLH;
                end
                PH_WA_SCLH: begin
                    eng_scl   = 1'b1;
                    eng_timer = 9'd0;
                    eng_phase = PH_WA_POLL;
                end
                // A low sample is the ACK; too many high samples turn into a stop.
                PH_WA_POLL: begin
                    if (!sda) begin
                        eng_scl   = 1'b0;
                        done      = 1'b1;
                        eng_phase = PH_IDLE;
                    end else begin
                        eng_timer = eng_timer + 9'd1;
                        if (eng_timer > {1'b0, eng_cfg.ack_timeout}) begin
                            eng_scl   = 1'b0;
                            eng_err   = 1'b1;
                            eng_phase = PH_SP_SDAL;
                        end
                    end
                end
                PH_RD_REL: begin
                    eng_sda   = 1'b1;
                    eng_phase = PH_RD_SCLH;
                end
                PH_RD_SCLH: begin
                    eng_scl   = 1'b1;
                    eng_phase = PH_RD_SAMP;
                end
                PH_RD_SAMP: begin
                    eng_shift = {eng_shift[6:0], sda};
                    eng_bits  = eng_bits + 4'd1;
                    eng_scl   = 1'b0;
                    eng_phase = (eng_bits >= BITS_PER_BYTE) ? PH_AK_SDA : PH_RD_SCLH;
                end
                PH_AK_SDA: begin
                    eng_sda   = !eng_ack_sel;
                    eng_phase = PH_AK_SCLH;
                end
                PH_AK_SCLH: begin
                    eng_scl   = 1'b1;
                    eng_phase = PH_AK_SCLL;
                end
                PH_AK_SCLL: begin
                    eng_scl   = 1'b0;
                    eng_rx    = eng_shift;
                    done      = 1'b1;
                    eng_phase = PH_IDLE;
                end
                default: eng_phase = PH_IDLE;
            endcase
        end
        res.scl_level   = eng_scl;
        res.sda_release = eng_sda;
        res.busy        = (eng_phase != PH_IDLE);
        res.done        = done;
        res.rx_byte     = eng_rx;
        res.ack_error   = eng_err;
    endtask

    // The slave side: ACK polls follow the ACK policy, read bits the read level.
    function automatic logic slave_sda_level();
        if (eng_phase == PH_WA_POLL) return ($urandom_range(99) < ack_high_pct);
        case (read_level)
            1:       return 1'b0;
            2:       return 1'b1;
            default: return 1'($urandom_range(1));
        endcase
    endfunction

    // Commands offered while busy: mostly none, sometimes any code, all to be ignored.
    function automatic logic [2:0] busy_cmd();
        if ($urandom_range(3) == 0) return 3'($urandom_range(7));
        return CMD_NONE;
    endfunction

    // Offers one tick word and records its predicted line state once it is taken.
    task automatic send_tick(input logic [2:0] cmd, input logic [7:0] tx, input logic ack);
        logic    sda;
        t_result res;
        sda = slave_sda_level();
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_tx_byte  <= tx;
        i_send_ack <= ack;
        i_sda_in   <= sda;
        do @(posedge i_clk); while (o_stall);
        advance_bus_tick(cmd, tx, ack, sda, res);
        line_state_q.push_back(res);
    endtask

    // Issues a command on an idle engine and keeps ticking until it has finished.
    task automatic run_op(input logic [2:0] cmd, input logic [7:0] tx, input logic ack);
        send_tick(cmd, tx, ack);
        if (cmd >= CMD_START && cmd <= CMD_READ) ops_issued++;
        while (eng_phase != PH_IDLE)
            send_tick(busy_cmd(), 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Brings the engine to idle, stops offering words and waits for every result.
    task automatic settle_engine();
        while (eng_phase != PH_IDLE)
            send_tick(busy_cmd(), 8'($urandom_range(255)), 1'($urandom_range(1)));
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (line_state_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START_HOLD:  eng_cfg.start_hold  = value;
            CFG_STOP_SETUP:  eng_cfg.stop_setup  = value;
            CFG_BUS_FREE:    eng_cfg.bus_free    = value;
            CFG_ACK_TIMEOUT: eng_cfg.ack_timeout = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [7:0] start_hold, input logic [7:0] stop_setup,
                              input logic [7:0] bus_free, input logic [7:0] ack_limit);
        settle_engine();
        write_reg(CFG_START_HOLD, start_hold);
        write_reg(CFG_STOP_SETUP, stop_setup);
        write_reg(CFG_BUS_FREE, bus_free);
        write_reg(CFG_ACK_TIMEOUT, ack_limit);
    endtask

    // One data byte in either direction; now and then the slave never answers the ACK.
    task automatic rand_data_op();
        read_level   = ($urandom_range(5) == 0) ? int'($urandom_range(1, 2)) : 0;
        ack_high_pct = ($urandom_range(24) == 0) ? 100 : 50;
        if ($urandom_range(1))
            run_op(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        else
            run_op(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
        read_level   = 0;
        ack_high_pct = 50;
    endtask

    // A bus transfer: mostly start, a few bytes, the odd repeated start and a stop;
    // otherwise a stray byte, a lone stop or a tick with no valid command.
    task automatic rand_xfer();
        int         n;
        logic [2:0] junk;
        if ($urandom_range(9) < 8) begin
            run_op(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
            n = $urandom_range(1, 4);
            repeat (n) begin
                rand_data_op();
                if ($urandom_range(9) == 0)
                    run_op(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            run_op(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
            case ($urandom_range(2))
                0: begin
                    junk = $urandom_range(1) ? 3'(CMD_NONE) : 3'($urandom_range(5, 7));
                    send_tick(junk, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                1: rand_data_op();
                default: run_op(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
            endcase
        end
    endtask

    // Field extremes, both ACK answers, unknown codes and a timed-out ACK at reset timing.
    task automatic test_directed();
        logic [2:0] code;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_op(CMD_START, 8'h00, 1'b0);
        ack_high_pct = 0;
        run_op(CMD_WRITE, 8'h00, 1'b0);
        run_op(CMD_WRITE, 8'hFF, 1'b1);
        run_op(CMD_WRITE, 8'hA5, 1'b0);
        read_level = 1;
        run_op(CMD_READ, 8'hFF, 1'b1);
        read_level = 2;
        run_op(CMD_READ, 8'h00, 1'b0);
        read_level = 0;
        run_op(CMD_READ, 8'h5A, 1'b1);
        ack_high_pct = 100;
        run_op(CMD_WRITE, 8'h3C, 1'b1);
        ack_high_pct = 50;
        for (int c = 0; c < 8; c++) begin
            code = 3'(c);
            if (code == CMD_NONE || code > CMD_READ) send_tick(code, 8'hFF, 1'b1);
        end
        run_op(CMD_START, 8'hFF, 1'b1);
        run_op(CMD_STOP, 8'h00, 1'b0);
    endtask

    // Random transfers under a sweep of timing settings, the extremes among them.
    task automatic test_timing_sweep();
        logic [7:0] sweep [5][4];
        int         target;
        sweep = '{'{8'd0, 8'd0, 8'd0, 8'd0},
                  '{8'd255, 8'd255, 8'd255, 8'd255},
                  '{8'd1, 8'd1, 8'd1, 8'd1},
                  '{8'd0, 8'd255, 8'd0, 8'd3},
                  '{8'($urandom_range(24)), 8'($urandom_range(24)),
                    8'($urandom_range(24)), 8'($urandom_range(24))}};
        for (int s = 0; s < 5; s++) begin
            set_timing(sweep[s][0], sweep[s][1], sweep[s][2], sweep[s][3]);
            target = ops_issued + OPS_PER_SETTING;
            while (ops_issued < target) rand_xfer();
        end
    endtask

    // Random transfers with sender gaps and receiver stalls in several mixes.
    task automatic test_idling();
        int idle_mix  [4];
        int stall_mix [4];
        int target;
        idle_mix  = '{0, 65, 0, 36};
        stall_mix = '{0, 0, 65, 36};
        set_timing(8'($urandom_range(6)), 8'($urandom_range(6)),
                   8'($urandom_range(6)), 8'($urandom_range(20)));
        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = idle_mix[p];
            sink_stall_pct = stall_mix[p];
            target = ops_issued + OPS_PER_PHASE;
            while (ops_issued < target) rand_xfer();
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // The receiver holds off for a long stretch while ticks keep coming, so the
    // engine fills up and has to stall its input.
    task automatic test_backpressure();
        settle_engine();
        fork
            begin
                @(posedge i_clk);
                sink_hold = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            begin
                repeat (2) rand_xfer();
            end
        join
    endtask

    // Receiver stall, random or held off for a stretch.
    always @(negedge i_clk) begin
        i_stall <= sink_hold || ($urandom_range(99) < sink_stall_pct);
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Every result word taken is checked against the oldest predicted line state.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (line_state_q.size() == 0) begin
                $error("result word with no prediction waiting");
                fail_count++;
            end else begin
                want = line_state_q.pop_front();
                compare_field("scl_level", want.scl_level, o_scl_level);
                compare_field("sda_release", want.sda_release, o_sda_release);
                compare_field("busy_res", want.busy, o_busy_res);
                compare_field("done_res", want.done, o_done_res);
                compare_field("rx_byte", want.rx_byte, o_rx_byte);
                compare_field("ack_error", want.ack_error, o_ack_error);
            end
        end
    end

    // Run limit.
    initial begin
        #(RUN_LIMIT);
        $display("tb_i2c_master_byte_engine failed");
        $finish;
    end

    initial begin
        reset_engine_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_timing_sweep();
        test_idling();
        test_backpressure();
        settle_engine();
        if (fail_count == 0 && line_state_q.size() == 0) begin
            $display("tb_i2c_master_byte_engine passed");
        end else begin
            $display("tb_i2c_master_byte_engine failed");
        end
        $finish;
    end

endmodule

[i2c_master_byte_engine.f]
+incdir+rtl
rtl/i2c_mbe_pkg.sv
rtl/i2c_mbe_cfg.sv
rtl/i2c_mbe_core.sv
rtl/i2c_master_byte_engine.sv
tb/sv/tb_i2c_master_byte_engine.sv
